// ----- rtl/scm_pkg.sv -----
// shared types, constants and helper functions of the scanning mixer
package scm_pkg;

   // fixed-point scales
   localparam int ONE_Q16    = 65536;
   localparam int ONE_Q15    = 32768;
   localparam int FULL_VOLTS = 20480;
   localparam int WIDTH_COEF = 12648;
   localparam int GAIN_ONE   = 512;
   // floor(x/5) = (x * RECIP_FIVE) >> RECIP_SHIFT for x below 2^22
   localparam int RECIP_FIVE  = 838861;
   localparam int RECIP_SHIFT = 22;

   // pipeline depths
   localparam int CTL_LAT  = 6;
   localparam int DIV_BITS = 16;
   localparam int LANE_LAT = DIV_BITS + 6;
   localparam int MRG_LAT  = 3;

   // window position and width words
   localparam int POS_W = 22;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_SCAN_KNOB       = 3'd0,
      REG_SCAN_CV_AMOUNT  = 3'd1,
      REG_WIDTH_KNOB      = 3'd2,
      REG_WIDTH_CV_AMOUNT = 3'd3,
      REG_SLOPE_KNOB      = 3'd4,
      REG_OUTPUT_LEVEL    = 3'd5,
      REG_LEVEL_CV_AMOUNT = 3'd6,
      REG_CHANNEL_GAINS   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [14:0] scan_knob;
      logic [15:0] scan_cv_amount;
      logic [14:0] width_knob;
      logic [15:0] width_cv_amount;
      logic [14:0] slope_knob;
      logic [15:0] output_level;
      logic [15:0] level_cv_amount;
      logic [59:0] channel_gains;
   } csr_type;

   // window description handed from the control path to the lanes
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] span;
      logic [16:0]      slope;
   } win_type;

   // q15 register saturated at 1.0
   function automatic logic [15:0] q15(input logic [15:0] r);
      logic [15:0] res;
      res = (r > 16'(ONE_Q15)) ? 16'(ONE_Q15) : r;
      return res;
   endfunction

   // clamp a control sum to 0..5 V
   function automatic logic [14:0] clamp_volts(input logic signed [33:0] v);
      logic [14:0] res;
      if (v[33]) begin
         res = 15'd0;
      end else if (v > 34'sd20480) begin
         res = 15'(FULL_VOLTS);
      end else begin
         res = v[14:0];
      end
      return res;
   endfunction

   // volts times 16, divided by 5, gives q16
   function automatic logic [16:0] norm16(input logic [18:0] v16);
      logic [38:0] m;
      m = v16 * 20'(RECIP_FIVE);
      return m[38:RECIP_SHIFT];
   endfunction

endpackage

// ----- rtl/scm_ctl.sv -----
// control path: clamps and normalises the cvs, forms the scan window and the level
module scm_ctl #(
   parameter int NUM_CHANNELS = 6
) (
   input  logic                clock,
   input  logic                en,
   input  scm_pkg::csr_type    csr,
   input  logic signed [15:0]  scan_cv,
   input  logic signed [15:0]  width_cv,
   input  logic signed [15:0]  slope_cv,
   input  logic signed [15:0]  level_cv,
   input  logic                level_patched,
   output scm_pkg::win_type    win,
   output logic [31:0]         level
);

   localparam int NN      = NUM_CHANNELS * NUM_CHANNELS;
   localparam int POS_W_L = scm_pkg::POS_W;

   // stage 1
   logic signed [32:0] scan_mul_ff, width_mul_ff;
   logic signed [16:0] slope_off_ff;
   logic [18:0]        lv16_ff;
   logic               lpat_ff;
   // stage 2
   logic [18:0] sv16_ff, cv16_ff, slv16_ff;
   logic [16:0] lvn_ff;
   // stage 3
   logic [16:0] s3_ff, c3_ff, sl3_ff, k3_ff;
   // stage 4
   logic [33:0] cc4_ff;
   logic [16:0] s4_ff, sl4_ff;
   logic [31:0] lvl4_ff;
   // stage 5
   logic [14:0] w5_ff;
   logic [16:0] s5_ff, sl5_ff;
   logic [31:0] lvl5_ff;
   // stage 6
   scm_pkg::win_type win_ff, win_in;
   logic [31:0]      lvl6_ff;

   logic [14:0]        lcv_clamped;
   logic signed [33:0] scan_sum, width_sum, slope_sum;
   logic [32:0]        k_mul, lvl_mul;
   logic [30:0]        w_mul;
   logic [POS_W_L-1:0] wx, sx;

   // cv times attenuator, slope offset, level clamp
   always_comb begin
      if (level_cv[15]) begin
         lcv_clamped = 15'd0;
      end else if (level_cv > 16'sd20480) begin
         lcv_clamped = 15'(scm_pkg::FULL_VOLTS);
      end else begin
         lcv_clamped = level_cv[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scan_mul_ff  <= scan_cv * $signed({1'b0, scm_pkg::q15(csr.scan_cv_amount)});
         width_mul_ff <= width_cv * $signed({1'b0, scm_pkg::q15(csr.width_cv_amount)});
         slope_off_ff <= $signed({slope_cv, 1'b0});
         lv16_ff      <= {lcv_clamped, 4'b0000};
         lpat_ff      <= level_patched;
      end
   end

   // knob plus offset, clamped
   assign scan_sum  = $signed({19'b0, csr.scan_knob}) + 34'(scan_mul_ff >>> 14);
   assign width_sum = $signed({19'b0, csr.width_knob}) + 34'(width_mul_ff >>> 14);
   assign slope_sum = $signed({19'b0, csr.slope_knob}) + 34'(slope_off_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sv16_ff  <= {scm_pkg::clamp_volts(scan_sum), 4'b0000};
         cv16_ff  <= {scm_pkg::clamp_volts(width_sum), 4'b0000};
         slv16_ff <= {scm_pkg::clamp_volts(slope_sum), 4'b0000};
         lvn_ff   <= lpat_ff ? scm_pkg::norm16(lv16_ff) : 17'(scm_pkg::ONE_Q16);
      end
   end

   // normalise, level crossfade
   assign k_mul = scm_pkg::q15(csr.level_cv_amount) * (17'(scm_pkg::ONE_Q16) - lvn_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff  <= scm_pkg::norm16(sv16_ff);
         c3_ff  <= scm_pkg::norm16(cv16_ff);
         sl3_ff <= scm_pkg::norm16(slv16_ff);
         k3_ff  <= 17'(scm_pkg::ONE_Q16) - k_mul[31:15];
      end
   end

   // width squared, master level
   assign lvl_mul = scm_pkg::q15(csr.output_level) * k3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cc4_ff  <= c3_ff * c3_ff;
         s4_ff   <= s3_ff;
         sl4_ff  <= sl3_ff;
         lvl4_ff <= lvl_mul[31:0];
      end
   end

   // width coefficient
   assign w_mul = cc4_ff[32:16] * 14'(scm_pkg::WIDTH_COEF);

   always_ff @(posedge clock) begin
      if (en) begin
         w5_ff   <= w_mul[30:16];
         s5_ff   <= s4_ff;
         sl5_ff  <= sl4_ff;
         lvl5_ff <= lvl4_ff;
      end
   end

   // window position and width in channel half-steps
   assign wx = POS_W_L'(w5_ff);
   assign sx = POS_W_L'(s5_ff);

   always_comb begin
      win_in.pos   = POS_W_L'(2) * (POS_W_L'(scm_pkg::ONE_Q16) - wx) + POS_W_L'(NN) * wx
                   + POS_W_L'(2 * NUM_CHANNELS - 2) * sx;
      win_in.span  = POS_W_L'(4) * (POS_W_L'(scm_pkg::ONE_Q16) - wx) + POS_W_L'(2 * NN) * wx;
      win_in.slope = sl5_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_ff  <= win_in;
         lvl6_ff <= lvl5_ff;
      end
   end

   assign win   = win_ff;
   assign level = lvl6_ff;

endmodule

// ----- rtl/scm_lane.sv -----
// one channel lane: window position divide, triangle and slope bend, gain and sample scaling
module scm_lane #(
   parameter int SAMPLE_BITS = 16,
   parameter int IDX         = 0
) (
   input  logic                          clock,
   input  logic                          en,
   input  scm_pkg::win_type              win,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [9:0]                    gain,
   input  logic                          active,
   output logic signed [SAMPLE_BITS+1:0] prod
);

   localparam int PW   = scm_pkg::POS_W;
   localparam int NB   = scm_pkg::DIV_BITS;
   localparam int FULL = SAMPLE_BITS + 29;

   // divider stages, index 0 is the entry register
   logic [PW-1:0]          rem_ff   [NB+1];
   logic [NB-1:0]          quo_ff   [NB+1];
   logic [PW-1:0]          span_ff  [NB+1];
   logic                   zero_ff  [NB+1];
   logic                   one_ff   [NB+1];
   logic [16:0]            sl_ff    [NB+1];
   logic [9:0]             gain_ff  [NB+1];
   logic                   act_ff   [NB+1];
   logic signed [SAMPLE_BITS-1:0] smp_ff [NB+1];

   logic signed [PW:0] num;
   logic               num_zero, num_one;

   // offset of this channel and range check
   assign num      = $signed({1'b0, win.pos}) - $signed((PW + 1)'(2 * IDX * scm_pkg::ONE_Q16));
   assign num_zero = (num <= 0);
   assign num_one  = !num_zero && (num >= $signed({1'b0, win.span}));

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= (num_zero || num_one) ? '0 : num[PW-1:0];
         quo_ff[0]  <= '0;
         span_ff[0] <= win.span;
         zero_ff[0] <= num_zero;
         one_ff[0]  <= num_one;
         sl_ff[0]   <= win.slope;
         gain_ff[0] <= gain;
         act_ff[0]  <= active;
         smp_ff[0]  <= sample;
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar j = 0; j < NB; j++) begin : g_div
      logic [PW-1:0] r2;
      logic          ge;
      assign r2 = {rem_ff[j][PW-2:0], 1'b0};
      assign ge = (r2 >= span_ff[j]);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= ge ? (r2 - span_ff[j]) : r2;
            quo_ff[j+1]  <= {quo_ff[j][NB-2:0], ge};
            span_ff[j+1] <= span_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            one_ff[j+1]  <= one_ff[j];
            sl_ff[j+1]   <= sl_ff[j];
            gain_ff[j+1] <= gain_ff[j];
            act_ff[j+1]  <= act_ff[j];
            smp_ff[j+1]  <= smp_ff[j];
         end
      end
   end

   // triangle
   logic [16:0] x, t_in;
   logic [16:0] t_ff, ta_ff;
   logic [16:0] slt_ff, sla_ff;
   logic [9:0]  gt_ff, ga_ff, gb_ff;
   logic        at_ff, aa_ff, ab_ff, ac_ff;
   logic signed [SAMPLE_BITS-1:0] st_ff, sa_ff, sb_ff, sc_ff;
   logic [15:0] tt_ff;
   logic [17:0] g_ff;
   logic [27:0] gm_ff;
   logic signed [SAMPLE_BITS+1:0] prod_ff;
   logic [33:0] tt_mul;
   logic [32:0] sl_mul;
   logic signed [FULL-1:0] full_mul;

   always_comb begin
      if (zero_ff[NB]) begin
         x = 17'd0;
      end else if (one_ff[NB]) begin
         x = 17'(scm_pkg::ONE_Q16);
      end else begin
         x = {1'b0, quo_ff[NB]};
      end
      if (x < 17'(scm_pkg::ONE_Q16 / 2)) begin
         t_in = {x[15:0], 1'b0};
      end else begin
         t_in = 17'(2 * (18'(scm_pkg::ONE_Q16) - {1'b0, x}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= t_in;
         slt_ff <= sl_ff[NB];
         gt_ff  <= gain_ff[NB];
         at_ff  <= act_ff[NB];
         st_ff  <= smp_ff[NB];
      end
   end

   // t times one minus t
   assign tt_mul = t_ff * (17'(scm_pkg::ONE_Q16) - t_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         tt_ff  <= tt_mul[31:16];
         ta_ff  <= t_ff;
         sla_ff <= slt_ff;
         ga_ff  <= gt_ff;
         aa_ff  <= at_ff;
         sa_ff  <= st_ff;
      end
   end

   // slope bend
   assign sl_mul = sla_ff * tt_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff  <= 18'(ta_ff) + 18'(sl_mul[32:16]);
         gb_ff <= ga_ff;
         ab_ff <= aa_ff;
         sb_ff <= sa_ff;
      end
   end

   // channel gain times window gain
   always_ff @(posedge clock) begin
      if (en) begin
         gm_ff <= gb_ff * g_ff;
         ac_ff <= ab_ff;
         sc_ff <= sb_ff;
      end
   end

   // sample scaling, floor of the shift
   assign full_mul = sc_ff * $signed({1'b0, gm_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= ac_ff ? full_mul[SAMPLE_BITS+26:25] : '0;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/scm_merge.sv -----
// merging stage: channel saturation, the three mixes and their level scaling
module scm_merge #(
   parameter int NUM_CHANNELS = 6,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [SAMPLE_BITS+1:0] prod [NUM_CHANNELS],
   input  logic [31:0]                   level,
   output logic signed [SAMPLE_BITS-1:0] out_ch [6],
   output logic signed [SAMPLE_BITS-1:0] mix_a,
   output logic signed [SAMPLE_BITS-1:0] mix_b,
   output logic signed [SAMPLE_BITS-1:0] mix_c
);

   localparam int PW  = SAMPLE_BITS + 2;
   localparam int MW  = PW + 3;
   localparam int PPW = MW + 17;
   localparam int TW  = MW + 34;
   localparam int SW  = TW - 31;
   localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] ch1_ff [6];
   logic signed [SAMPLE_BITS-1:0] ch2_ff [6];
   logic signed [SAMPLE_BITS-1:0] ch3_ff [6];
   logic signed [MW-1:0]  sum_in [3];
   logic signed [MW-1:0]  sum_ff [3];
   logic [31:0]           lvl1_ff;
   logic signed [PPW-1:0] pph_ff [3];
   logic signed [PPW-1:0] ppl_ff [3];
   logic signed [SAMPLE_BITS-1:0] mix_ff [3];
   logic signed [SAMPLE_BITS-1:0] ch_sat [6];
   logic signed [SAMPLE_BITS-1:0] mix_sat [3];

   // channel saturation and mix sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
         ch_sat[i] = '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (&prod[i][PW-1:SAMPLE_BITS-1] || ~|prod[i][PW-1:SAMPLE_BITS-1]) begin
            ch_sat[i] = prod[i][SAMPLE_BITS-1:0];
         end else begin
            ch_sat[i] = prod[i][PW-1] ? SAT_LO : SAT_HI;
         end
         sum_in[1] = sum_in[1] + MW'(prod[i]);
         if (i <= 1) begin
            sum_in[0] = sum_in[0] + MW'(prod[i]);
         end
         if (i >= 4) begin
            sum_in[2] = sum_in[2] + MW'(prod[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ch1_ff  <= ch_sat;
         sum_ff  <= sum_in;
         lvl1_ff <= level;
      end
   end

   // partial products of mix times level
   always_ff @(posedge clock) begin
      if (en) begin
         ch2_ff <= ch1_ff;
         for (int m = 0; m < 3; m++) begin
            pph_ff[m] <= sum_ff[m] * $signed({1'b0, lvl1_ff[31:16]});
            ppl_ff[m] <= sum_ff[m] * $signed({1'b0, lvl1_ff[15:0]});
         end
      end
   end

   // recombine, floor shift, saturate
   always_comb begin
      logic signed [TW-1:0] tot;
      logic signed [SW-1:0] sh;
      for (int m = 0; m < 3; m++) begin
         tot = (TW'(pph_ff[m]) <<< 16) + TW'(ppl_ff[m]);
         sh  = tot[TW-1:31];
         if (&sh[SW-1:SAMPLE_BITS-1] || ~|sh[SW-1:SAMPLE_BITS-1]) begin
            mix_sat[m] = sh[SAMPLE_BITS-1:0];
         end else begin
            mix_sat[m] = sh[SW-1] ? SAT_LO : SAT_HI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ch3_ff <= ch2_ff;
         mix_ff <= mix_sat;
      end
   end

   assign out_ch = ch3_ff;
   assign mix_a  = mix_ff[0];
   assign mix_b  = mix_ff[1];
   assign mix_c  = mix_ff[2];

endmodule

// ----- rtl/six_channel_scanning_mixer.sv -----
// top level of the six-channel scanning crossfade mixer
// requests pass through the control path, the lanes and the merge stage, in that order
// throughput: one item per cycle when not stalled; lane depth set by the 16-stage divider
// a stall on the result side freezes the whole pipeline and holds off input transfers
// reset (synchronous, active high) empties the pipeline and clears the configuration registers
module six_channel_scanning_mixer #(
   parameter int NUM_CHANNELS = 6,
   parameter int SAMPLE_BITS  = 16,
   localparam int REQ_W = ((6 * SAMPLE_BITS + 70 + 7) / 8) * 8,
   localparam int RSP_W = ((9 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // sample_ch0..5, connected_mask, scan_cv, width_cv, slope_cv, level_cv
   input  logic [REQ_W-1:0]         req_tdata,
   // level_patched
   input  logic [0:0]               req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // out_ch0..5, mix_a, mix_b, mix_c
   output logic [RSP_W-1:0]         rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [2:0]               csr_addr,
   input  logic [59:0]              csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int CB    = 6 * SAMPLE_BITS;
   localparam int TOT   = scm_pkg::CTL_LAT + scm_pkg::LANE_LAT + scm_pkg::MRG_LAT;

   scm_pkg::csr_type csr_ff;
   logic             en;
   logic             vld_ff [TOT];
   logic signed [SB-1:0] smp_dly_ff [scm_pkg::CTL_LAT][NUM_CHANNELS];
   logic [5:0]           msk_dly_ff [scm_pkg::CTL_LAT];
   logic [31:0]          lvl_dly_ff [scm_pkg::LANE_LAT];
   scm_pkg::win_type     win;
   logic [31:0]          level;
   logic signed [SB+1:0] prod [NUM_CHANNELS];
   logic signed [SB-1:0] out_ch [6];
   logic signed [SB-1:0] mix_a, mix_b, mix_c;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_we) begin
         unique case (scm_pkg::reg_index_type'(csr_addr))
            scm_pkg::REG_SCAN_KNOB:       csr_ff.scan_knob       <= csr_wdata[14:0];
            scm_pkg::REG_SCAN_CV_AMOUNT:  csr_ff.scan_cv_amount  <= csr_wdata[15:0];
            scm_pkg::REG_WIDTH_KNOB:      csr_ff.width_knob      <= csr_wdata[14:0];
            scm_pkg::REG_WIDTH_CV_AMOUNT: csr_ff.width_cv_amount <= csr_wdata[15:0];
            scm_pkg::REG_SLOPE_KNOB:      csr_ff.slope_knob      <= csr_wdata[14:0];
            scm_pkg::REG_OUTPUT_LEVEL:    csr_ff.output_level    <= csr_wdata[15:0];
            scm_pkg::REG_LEVEL_CV_AMOUNT: csr_ff.level_cv_amount <= csr_wdata[15:0];
            scm_pkg::REG_CHANNEL_GAINS:   csr_ff.channel_gains   <= csr_wdata;
         endcase
      end
   end

   // pipeline advance and occupancy
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < TOT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[TOT-1];

   // control path
   scm_ctl #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_ctl (
      .clock         (clock),
      .en            (en),
      .csr           (csr_ff),
      .scan_cv       ($signed(req_tdata[CB+21:CB+6])),
      .width_cv      ($signed(req_tdata[CB+37:CB+22])),
      .slope_cv      ($signed(req_tdata[CB+53:CB+38])),
      .level_cv      ($signed(req_tdata[CB+69:CB+54])),
      .level_patched (req_tuser[0]),
      .win           (win),
      .level         (level)
   );

   // samples and mask wait for the window
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            smp_dly_ff[0][i] <= $signed(req_tdata[i*SB +: SB]);
         end
         msk_dly_ff[0] <= req_tdata[CB+5:CB];
         for (int k = 1; k < scm_pkg::CTL_LAT; k++) begin
            smp_dly_ff[k] <= smp_dly_ff[k-1];
            msk_dly_ff[k] <= msk_dly_ff[k-1];
         end
      end
   end

   // level waits for the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         lvl_dly_ff[0] <= level;
         for (int k = 1; k < scm_pkg::LANE_LAT; k++) begin
            lvl_dly_ff[k] <= lvl_dly_ff[k-1];
         end
      end
   end

   // one lane per channel
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      logic [9:0] raw_gain, sat_gain;
      assign raw_gain = csr_ff.channel_gains[10*i +: 10];
      assign sat_gain = (raw_gain > 10'(scm_pkg::GAIN_ONE)) ? 10'(scm_pkg::GAIN_ONE) : raw_gain;

      scm_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .IDX         (i)
      ) u_lane (
         .clock  (clock),
         .en     (en),
         .win    (win),
         .sample (smp_dly_ff[scm_pkg::CTL_LAT-1][i]),
         .gain   (sat_gain),
         .active (msk_dly_ff[scm_pkg::CTL_LAT-1][i]),
         .prod   (prod[i])
      );
   end

   // merge
   scm_merge #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_merge (
      .clock  (clock),
      .en     (en),
      .prod   (prod),
      .level  (lvl_dly_ff[scm_pkg::LANE_LAT-1]),
      .out_ch (out_ch),
      .mix_a  (mix_a),
      .mix_b  (mix_b),
      .mix_c  (mix_c)
   );

   // result packing
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 6; i++) begin
         rsp_tdata[i*SB +: SB] = out_ch[i];
      end
      rsp_tdata[6*SB +: SB] = mix_a;
      rsp_tdata[7*SB +: SB] = mix_b;
      rsp_tdata[8*SB +: SB] = mix_c;
   end

endmodule

// ----- rtl/scm_checker.sv -----
// port checker of the scanning mixer, bound to the top level
module scm_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [143:0] rsp_tdata
);

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // empty output means intake is open
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with no pending result");

   // a stalled result freezes intake
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline frozen");

endmodule

bind six_channel_scanning_mixer scm_checker u_scm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata[143:0])
);
